@@ design/alcu_pkg.sv @@
// ----------------------------------------------------------------------------
// alcu_pkg
// Beat types, operation codes and status codes for the array list unit.
// ----------------------------------------------------------------------------
package alcu_pkg;

  localparam int FUNC_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 4'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 4'd1;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 4'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 4'd3;
  localparam logic [FUNC_W-1:0] FUNC_START  = 4'd4;
  localparam logic [FUNC_W-1:0] FUNC_END    = 4'd5;
  localparam logic [FUNC_W-1:0] FUNC_PREV   = 4'd6;
  localparam logic [FUNC_W-1:0] FUNC_NEXT   = 4'd7;
  localparam logic [FUNC_W-1:0] FUNC_TO_POS = 4'd8;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ELEM = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] item_value;
    logic [POS_W-1:0]   target_position;
  } alcu_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  element_value;
    logic [POS_W-1:0]    list_length;
    logic [POS_W-1:0]    cursor_position;
    logic [STATUS_W-1:0] status;
  } alcu_out_t;

endpackage

@@ design/alcu_ram.sv @@
// ----------------------------------------------------------------------------
// alcu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module alcu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ design/alcu_ctrl.sv @@
// ----------------------------------------------------------------------------
// alcu_ctrl
// Sequencer for the list: holds length and cursor, walks one index counter
// through the element RAM to shift entries for insert and remove.
// ----------------------------------------------------------------------------
module alcu_ctrl
  import alcu_pkg::*;
#(
  parameter int CAPACITY      = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  alcu_in_t              in_data,
  output logic                  mem_we,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] mem_waddr,
  output logic [ELEMENT_WIDTH-1:0] mem_wdata,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] mem_raddr,
  input  logic [ELEMENT_WIDTH-1:0] mem_rdata,
  output logic                  res_valid,
  input  logic                  res_ready,
  output alcu_out_t             res_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DEC     = 3'd1;
  localparam logic [2:0] S_INS_WR  = 3'd2;
  localparam logic [2:0] S_INS_PUT = 3'd3;
  localparam logic [2:0] S_RM_CAP  = 3'd4;
  localparam logic [2:0] S_RM_WR   = 3'd5;
  localparam logic [2:0] S_RD_CAP  = 3'd6;
  localparam logic [2:0] S_RESP    = 3'd7;

  logic [2:0]               state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            cursor_r, cursor_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [FUNC_W-1:0]        func_r;
  logic [ELEMENT_WIDTH-1:0] item_r;
  logic [POS_W-1:0]         tgt_r;
  logic [VALUE_W-1:0]       value_r, value_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;

  logic [CW-1:0]  idx_m1, idx_m2, cnt_m1, cnt_p1;
  logic [CW:0]    idx_p1, idx_p2, cnt_x;
  logic           full;
  logic           no_elem;
  logic [63:0]    item_w;
  logic [63:0]    rd_w;
  logic [31:0]    cnt_w, cur_w, tgt_w;

  // Shared index arithmetic used by every shift step
  assign idx_m1 = idx_r - CW'(1);
  assign idx_m2 = idx_r - CW'(2);
  assign idx_p1 = {1'b0, idx_r} + (CW+1)'(1);
  assign idx_p2 = {1'b0, idx_r} + (CW+1)'(2);
  assign cnt_x  = {1'b0, count_r};
  assign cnt_m1 = count_r - CW'(1);
  assign cnt_p1 = count_r + CW'(1);
  assign full    = (count_r == CW'(CAPACITY));
  assign no_elem = (cursor_r >= count_r);

  assign item_w = 64'(in_data.item_value);
  assign rd_w   = 64'(mem_rdata);
  assign cnt_w  = 32'(count_r);
  assign cur_w  = 32'(cursor_r);
  assign tgt_w  = 32'(tgt_r);

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res_data.element_value   = value_r;
  assign res_data.list_length     = cnt_w[POS_W-1:0];
  assign res_data.cursor_position = cur_w[POS_W-1:0];
  assign res_data.status          = status_r;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    idx_nxt    = idx_r;
    value_nxt  = value_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r[AW-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        value_nxt  = '0;
        status_nxt = ST_OK;
        state_nxt  = S_RESP;
        case (func_r)
          FUNC_CLEAR: begin
            count_nxt  = '0;
            cursor_nxt = '0;
          end
          FUNC_INSERT: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else if (count_r > cursor_r) begin
              mem_raddr = cnt_m1[AW-1:0];
              idx_nxt   = count_r;
              state_nxt = S_INS_WR;
            end else begin
              state_nxt = S_INS_PUT;
            end
          end
          FUNC_APPEND: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_r[AW-1:0];
              mem_wdata = item_r;
              count_nxt = cnt_p1;
            end
          end
          FUNC_REMOVE: begin
            if (no_elem) begin
              status_nxt = ST_NO_ELEM;
            end else begin
              mem_raddr = cursor_r[AW-1:0];
              idx_nxt   = cursor_r;
              state_nxt = S_RM_CAP;
            end
          end
          FUNC_START: cursor_nxt = '0;
          FUNC_END:   cursor_nxt = count_r;
          FUNC_PREV: begin
            if (cursor_r != '0) begin
              cursor_nxt = cursor_r - CW'(1);
            end
          end
          FUNC_NEXT: begin
            if (cursor_r < count_r) begin
              cursor_nxt = cursor_r + CW'(1);
            end
          end
          FUNC_TO_POS: begin
            if (tgt_w > cnt_w) begin
              status_nxt = ST_RANGE;
            end else begin
              cursor_nxt = tgt_w[CW-1:0];
            end
          end
          FUNC_READ: begin
            if (no_elem) begin
              status_nxt = ST_NO_ELEM;
            end else begin
              mem_raddr = cursor_r[AW-1:0];
              state_nxt = S_RD_CAP;
            end
          end
          default: ;
        endcase
      end
      S_INS_WR: begin
        // move entry idx-1 up to idx, fetch the next one down meanwhile
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = mem_rdata;
        idx_nxt   = idx_m1;
        if (idx_m1 > cursor_r) begin
          mem_raddr = idx_m2[AW-1:0];
        end else begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = cursor_r[AW-1:0];
        mem_wdata = item_r;
        count_nxt = cnt_p1;
        state_nxt = S_RESP;
      end
      S_RM_CAP: begin
        value_nxt = rd_w[VALUE_W-1:0];
        if (idx_p1 < cnt_x) begin
          mem_raddr = idx_p1[AW-1:0];
          state_nxt = S_RM_WR;
        end else begin
          count_nxt = cnt_m1;
          state_nxt = S_RESP;
        end
      end
      S_RM_WR: begin
        // move entry idx+1 down to idx, fetch the next one up meanwhile
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = mem_rdata;
        idx_nxt   = idx_p1[CW-1:0];
        if (idx_p2 < cnt_x) begin
          mem_raddr = idx_p2[AW-1:0];
        end else begin
          count_nxt = cnt_m1;
          state_nxt = S_RESP;
        end
      end
      S_RD_CAP: begin
        value_nxt = rd_w[VALUE_W-1:0];
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      cursor_r <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    value_r  <= value_nxt;
    status_r <= status_nxt;
    if (state_r == S_IDLE && in_valid) begin
      func_r <= in_data.func;
      item_r <= item_w[ELEMENT_WIDTH-1:0];
      tgt_r  <= in_data.target_position;
    end
  end

endmodule

@@ design/array_list_with_cursor_unit.sv @@
// ----------------------------------------------------------------------------
// array_list_with_cursor_unit
// Bounded array list with a cursor: insert, append, remove, cursor moves and
// read, one result beat per operation beat.
// ----------------------------------------------------------------------------
//   channel   ports                        beat
//   input     in_valid  in_stall  in_data  operation, item, target position
//   result    out_valid out_stall out_data value, length, cursor, status
//
// Cursor moves, clear, append and failed operations go from decode straight to
// the result. Read adds a RAM read; insert and remove shift the elements in
// between, moving one RAM entry per cycle.
// in_stall is high while an operation is in flight. The result register lets a
// new beat be accepted while the previous result waits on out_stall. Reset
// clears length and cursor; the element RAM is left as is.
// ----------------------------------------------------------------------------
module array_list_with_cursor_unit
  import alcu_pkg::*;
#(
  parameter int CAPACITY      = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  alcu_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output alcu_out_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_rdata;
  logic                     res_valid;
  logic                     res_ready;
  alcu_out_t                res_data;
  logic                     out_valid_r;
  alcu_out_t                out_data_r;

  alcu_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  alcu_ctrl #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // load a new result once the held beat is gone or leaving
  assign res_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

endmodule

@@ tb/sv/array_list_with_cursor_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_with_cursor_unit_test
// Drives operation beats into the array list unit and checks every result
// beat against a list model kept in the bench. Both channels idle and stall
// at random. The run covers an empty list, a full list, cursor moves at the
// edges, shifts over the whole list and unused operation codes.
// ----------------------------------------------------------------------------
module array_list_with_cursor_unit_test;
  import alcu_pkg::*;

  localparam int LIST_CAP     = 16;
  localparam int LIST_AW      = $clog2(LIST_CAP);
  localparam int RANDOM_OPS   = 1000;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED_TOP = 4'hF;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX, BURST_NOISE} burst_kind_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  alcu_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  alcu_out_t out_data;

  alcu_in_t  op_queue[$];
  alcu_out_t expected_results[$];

  // list as the block should hold it
  logic [VALUE_W-1:0] list_mem [LIST_CAP];
  logic [POS_W-1:0]   list_len = '0;
  logic [POS_W-1:0]   list_cur = '0;

  int errors = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit in_steady = 1'b0;
  bit out_steady = 1'b0;

  array_list_with_cursor_unit #(
    .CAPACITY      (LIST_CAP),
    .ELEMENT_WIDTH (VALUE_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Apply one operation to the list copy and return the result it yields.
  function automatic alcu_out_t apply_list_op(alcu_in_t op);
    alcu_out_t res;
    int i;
    res = '0;
    res.status = ST_OK;
    case (op.func)
      FUNC_CLEAR: begin
        list_len = '0;
        list_cur = '0;
      end
      FUNC_INSERT: begin
        if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          for (i = int'(list_len); i > int'(list_cur); i--) list_mem[i] = list_mem[i-1];
          list_mem[list_cur[LIST_AW-1:0]] = op.item_value;
          list_len = list_len + 1'b1;
        end
      end
      FUNC_APPEND: begin
        if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          list_mem[list_len[LIST_AW-1:0]] = op.item_value;
          list_len = list_len + 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (list_cur >= list_len) begin
          res.status = ST_NO_ELEM;
        end else begin
          res.element_value = list_mem[list_cur[LIST_AW-1:0]];
          for (i = int'(list_cur); i + 1 < int'(list_len); i++) list_mem[i] = list_mem[i+1];
          list_len = list_len - 1'b1;
        end
      end
      FUNC_START: list_cur = '0;
      FUNC_END:   list_cur = list_len;
      FUNC_PREV: begin
        if (list_cur != 0) list_cur = list_cur - 1'b1;
      end
      FUNC_NEXT: begin
        if (list_cur < list_len) list_cur = list_cur + 1'b1;
      end
      FUNC_TO_POS: begin
        if (op.target_position > list_len) res.status = ST_RANGE;
        else list_cur = op.target_position;
      end
      FUNC_READ: begin
        if (list_cur >= list_len) res.status = ST_NO_ELEM;
        else res.element_value = list_mem[list_cur[LIST_AW-1:0]];
      end
      default: ;
    endcase
    res.list_length     = list_len;
    res.cursor_position = list_cur;
    return res;
  endfunction

  function automatic alcu_in_t make_op(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v,
                                       logic [POS_W-1:0] t);
    alcu_in_t op;
    op.func            = f;
    op.item_value      = v;
    op.target_position = t;
    return op;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_target();
    if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, LIST_CAP));
    return POS_W'($urandom_range(0, 31));
  endfunction

  // Mostly short, a few long; zero while a steady stretch lasts.
  function automatic int pick_idle(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(burst_kind_t kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      BURST_FILL: begin
        if (r < 35) return FUNC_INSERT;
        if (r < 65) return FUNC_APPEND;
        if (r < 70) return FUNC_START;
        if (r < 75) return FUNC_END;
        if (r < 80) return FUNC_PREV;
        if (r < 85) return FUNC_NEXT;
        if (r < 90) return FUNC_TO_POS;
        return FUNC_READ;
      end
      BURST_DRAIN: begin
        if (r < 45) return FUNC_REMOVE;
        if (r < 60) return FUNC_READ;
        if (r < 65) return FUNC_INSERT;
        if (r < 72) return FUNC_START;
        if (r < 79) return FUNC_END;
        if (r < 86) return FUNC_PREV;
        if (r < 93) return FUNC_NEXT;
        return FUNC_TO_POS;
      end
      BURST_MIX: begin
        if (r < 2) return FUNC_CLEAR;
        return FUNC_W'($urandom_range(FUNC_INSERT, FUNC_READ));
      end
      default: return FUNC_W'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: hold the beat until accepted, then advance after a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(apply_list_op(in_data));
      if (!in_valid || !in_stall) begin
        if ($urandom_range(0, 199) == 0) in_steady = !in_steady;
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          in_data  <= op_queue.pop_front();
          in_valid <= 1'b1;
          gap_left = pick_idle(in_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result beat, stall at random.
  always @(posedge clk) begin : result_monitor
    alcu_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %0h", $time, out_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("element_value", want.element_value, out_data.element_value);
          check_field("list_length", VALUE_W'(want.list_length),
                      VALUE_W'(out_data.list_length));
          check_field("cursor_position", VALUE_W'(want.cursor_position),
                      VALUE_W'(out_data.cursor_position));
          check_field("status", VALUE_W'(want.status), VALUE_W'(out_data.status));
        end
      end
      if ($urandom_range(0, 199) == 0) out_steady = !out_steady;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!out_steady && $urandom_range(0, 99) < 30) begin
        stall_left = pick_idle(1'b0);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int n;
    int len;
    int i;
    burst_kind_t kind;
    logic [FUNC_W-1:0] f;

    // empty list: nothing at the cursor, cursor pinned at both edges
    op_queue.push_back(make_op(FUNC_READ, '1, '0));
    op_queue.push_back(make_op(FUNC_REMOVE, '0, '0));
    op_queue.push_back(make_op(FUNC_PREV, '0, '0));
    op_queue.push_back(make_op(FUNC_NEXT, '0, '0));
    op_queue.push_back(make_op(FUNC_TO_POS, '0, 5'd1));
    op_queue.push_back(make_op(FUNC_UNUSED_TOP, '1, '1));
    // fill to capacity, inserting at the head so every shift spans the list
    op_queue.push_back(make_op(FUNC_INSERT, '1, '0));
    op_queue.push_back(make_op(FUNC_APPEND, '0, '0));
    for (i = 0; i < LIST_CAP - 2; i++)
      op_queue.push_back(make_op(i[0] ? FUNC_APPEND : FUNC_INSERT, $urandom, '0));
    op_queue.push_back(make_op(FUNC_INSERT, $urandom, '0));
    op_queue.push_back(make_op(FUNC_APPEND, $urandom, '0));
    op_queue.push_back(make_op(FUNC_TO_POS, '0, '1));
    op_queue.push_back(make_op(FUNC_TO_POS, '0, POS_W'(LIST_CAP)));
    op_queue.push_back(make_op(FUNC_NEXT, '0, '0));
    op_queue.push_back(make_op(FUNC_READ, '0, '0));
    op_queue.push_back(make_op(FUNC_PREV, '0, '0));
    op_queue.push_back(make_op(FUNC_REMOVE, '0, '0));
    op_queue.push_back(make_op(FUNC_START, '0, '0));
    op_queue.push_back(make_op(FUNC_REMOVE, '0, '0));
    op_queue.push_back(make_op(FUNC_TO_POS, '0, '0));
    op_queue.push_back(make_op(FUNC_CLEAR, '0, '0));

    // random bursts; unused codes do not count toward the total
    n = 0;
    while (n < RANDOM_OPS) begin
      i = $urandom_range(0, 99);
      kind = (i < 30) ? BURST_FILL : (i < 60) ? BURST_DRAIN : (i < 90) ? BURST_MIX :
             BURST_NOISE;
      len = $urandom_range(20, 60);
      for (i = 0; i < len; i++) begin
        f = pick_func(kind);
        if (kind == BURST_NOISE)
          op_queue.push_back(make_op(f, $urandom, POS_W'($urandom_range(0, 31))));
        else op_queue.push_back(make_op(f, pick_value(), pick_target()));
        if (f <= FUNC_READ) n++;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // sample between edges so the driver and monitor updates have settled
    @(negedge clk);
    while ((op_queue.size() > 0 || in_valid || expected_results.size() > 0) &&
           cycle_count < CYCLE_LIMIT)
      @(negedge clk);

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("array_list_with_cursor_unit_test: FAIL");
    end else begin
      // catch any stray beat after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (errors == 0 && expected_results.size() == 0) begin
        $display("array_list_with_cursor_unit_test: PASS");
      end else begin
        $display("array_list_with_cursor_unit_test: FAIL");
      end
    end
    $finish;
  end

endmodule
